/* rtl/tbg_pkg.sv */
// ----------------------------------------------------------------------------
// tbg_pkg: shared types and constants for the tachometer bar gauge
// Register codes, zone codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tbg_pkg;

    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 16;
    localparam int PIX_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MIN_GAP_W   = 20;
    localparam int STALE_W     = 24;

    // divider numerator width: covers 60e6 and speed * bar length (bar <= 1023)
    localparam int DIV_NW      = 26;

    localparam logic [DIV_NW-1:0] RPM_NUMERATOR = 26'd60000000;

    // floor(x / 5) == (x * 0xCCCCCCCD) >> 34 for any 32-bit x
    localparam logic [31:0] RECIP5       = 32'hCCCCCCCD;
    localparam int          RECIP5_SHIFT = 34;

    localparam logic [MIN_GAP_W-1:0] MIN_GAP_RST    = 20'd5000;
    localparam logic [STALE_W-1:0]   STALE_RST      = 24'd500000;
    localparam logic [SPEED_W-1:0]   WARN_RST       = 16'd7000;
    localparam logic [SPEED_W-1:0]   DANGER_RST     = 16'd8500;
    localparam logic [SPEED_W-1:0]   FULL_SCALE_RST = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GAP    = 3'd0,
        CFG_STALE      = 3'd1,
        CFG_WARN       = 3'd2,
        CFG_DANGER     = 3'd3,
        CFG_FULL_SCALE = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        REQ_PULSE   = 1'b0,
        REQ_REFRESH = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ZONE_NORMAL = 2'd0,
        ZONE_WARN   = 2'd1,
        ZONE_DANGER = 2'd2
    } t_zone;

    typedef enum logic {
        DIV_INST  = 1'b0,   // 60e6 / period
        DIV_WIDTH = 1'b1    // speed * bar length / full scale
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_INST,
        S_SMOOTH_MUL,
        S_SMOOTH_SAT,
        S_SCALE_MUL,
        S_DIV_START,
        S_DIV_WIDTH,
        S_SPAN
    } t_state;

    typedef struct packed {
        logic     pulse;
        logic     cap_now;
        logic     zero_speed;
        logic     div_start;
        t_div_sel div_sel;
        logic     smooth_mul;
        logic     smooth_sat;
        logic     scale_mul;
        logic     width_load;
        logic     span_load;
    } t_dp_cmd;

    typedef struct packed {
        logic stale;
        logic has_period;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/tachometer_bar_gauge.sv */
// Sequence: a pulse word completes in the cycle it is accepted. A refresh word
//   with a known period and a live speed runs two 26-step divides in one
//   shared radix-2 divider, plus smoothing, scaling and span steps; a stale
//   speed or a missing period skips the first divide and the smoothing.
// Flow: one word at a time; the next word is taken in the cycle after the
//   result loads, later while the result waits.
// Reset: synchronous, active low; config returns to defaults, state clears.
// ----------------------------------------------------------------------------
// tachometer_bar_gauge: pulse-period tachometer driving an incremental bar
// Pulse words time the shaft; refresh words produce a smoothed speed, a bar
// width, a color zone and the fill/clear spans needed to repaint the bar.
// ----------------------------------------------------------------------------
`default_nettype none

module tachometer_bar_gauge import tbg_pkg::*; #(
    parameter int BAR_LENGTH = 458
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // config write channel, always ready
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [TIME_W-1:0]     i_now_us,

    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [SPEED_W-1:0]    o_speed_rpm,
    output logic      [PIX_W-1:0]      o_bar_width,
    output logic      [1:0]            o_color_zone,
    output logic      [PIX_W-1:0]      o_fill_start,
    output logic      [PIX_W-1:0]      o_fill_length,
    output logic      [PIX_W-1:0]      o_clear_start,
    output logic      [PIX_W-1:0]      o_clear_length
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config registers sit in the datapath; writes are registered
    assign o_cfg_ready = 1'b1;

    // Controller: accepts a word only when idle. A finished result waits in
    // the output register while the next word is taken; a refresh that
    // finishes while the previous result is still unclaimed holds in its
    // last step until the register frees up.
    tbg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Datapath: pulse gating by wrapped time gap, stale check, 60e6/period
    // and width division through one divider, smoothing by 4/5 weighting
    // with a reciprocal multiply for the /5, then zone and span selection.
    tbg_dp #(
        .BAR_LENGTH (BAR_LENGTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_now_us       (i_now_us),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_speed_rpm    (o_speed_rpm),
        .o_bar_width    (o_bar_width),
        .o_color_zone   (o_color_zone),
        .o_fill_start   (o_fill_start),
        .o_fill_length  (o_fill_length),
        .o_clear_start  (o_clear_start),
        .o_clear_length (o_clear_length)
    );

endmodule

`default_nettype wire

/* rtl/tbg_div.sv */
// ----------------------------------------------------------------------------
// tbg_div: restoring divider, one quotient bit per cycle
// Unsigned NW-bit numerator over DW-bit divisor; done pulses in the cycle
// after the last step and the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_div import tbg_pkg::*; #(
    parameter int NW = 26,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [NW-1:0] o_quot,
    output logic               o_done
);

    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic [DW:0]      trial;
    logic             fits;

    assign trial = {r_rem, r_num[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the numerator register from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_num <= {r_num[NW-2:0], fits};
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/tbg_ctrl.sv */
// ----------------------------------------------------------------------------
// tbg_ctrl: sequencer for pulse and refresh words
// Pulses complete on acceptance; refreshes step the datapath through divide,
// smooth (live period), scale, divide, span, then load the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_ctrl import tbg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_req_type,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   slot_free;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_req_type == REQ_REFRESH) n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_sts.stale)      n_state = S_SCALE_MUL;
                else if (i_sts.has_period)     n_state = S_DIV_INST;
                else                           n_state = S_SCALE_MUL;
            end
            S_DIV_INST: begin
                if (i_sts.div_done) n_state = S_SMOOTH_MUL;
            end
            S_SMOOTH_MUL: n_state = S_SMOOTH_SAT;
            S_SMOOTH_SAT: n_state = S_SCALE_MUL;
            S_SCALE_MUL:  n_state = S_DIV_START;
            S_DIV_START:  n_state = S_DIV_WIDTH;
            S_DIV_WIDTH: begin
                if (i_sts.div_done) n_state = S_SPAN;
            end
            S_SPAN: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.pulse   = in_acc && i_req_type == REQ_PULSE;
                o_cmd.cap_now = in_acc && i_req_type == REQ_REFRESH;
            end
            S_CHECK: begin
                o_cmd.zero_speed = i_sts.stale;
                o_cmd.div_start  = !i_sts.stale && i_sts.has_period;
                o_cmd.div_sel    = DIV_INST;
            end
            S_DIV_INST: begin
                o_cmd.div_sel = DIV_INST;
            end
            S_SMOOTH_MUL: begin
                o_cmd.smooth_mul = 1'b1;
            end
            S_SMOOTH_SAT: begin
                o_cmd.smooth_sat = 1'b1;
            end
            S_SCALE_MUL: begin
                o_cmd.scale_mul = 1'b1;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_WIDTH;
            end
            S_DIV_WIDTH: begin
                o_cmd.div_sel    = DIV_WIDTH;
                o_cmd.width_load = i_sts.div_done;
            end
            S_SPAN: begin
                o_cmd.span_load = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.span_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/tbg_dp.sv */
// ----------------------------------------------------------------------------
// tbg_dp: tachometer datapath
// Config registers, pulse timing state, shared divider, smoothing,
// bar scaling, zone and span logic, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_dp import tbg_pkg::*; #(
    parameter int BAR_LENGTH = 458
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [TIME_W-1:0]     i_now_us,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    output logic      [SPEED_W-1:0]    o_speed_rpm,
    output logic      [PIX_W-1:0]      o_bar_width,
    output logic      [1:0]            o_color_zone,
    output logic      [PIX_W-1:0]      o_fill_start,
    output logic      [PIX_W-1:0]      o_fill_length,
    output logic      [PIX_W-1:0]      o_clear_start,
    output logic      [PIX_W-1:0]      o_clear_length
);

    localparam int             BW      = $clog2(BAR_LENGTH + 1);
    localparam logic [BW-1:0]  BAR_MAX = BW'(BAR_LENGTH);
    localparam int             MUL_W   = SPEED_W + BW;
    localparam int             SUM_W   = DIV_NW + 1;
    localparam int             PROD_W  = SUM_W + 32;
    localparam int             Q5_W    = PROD_W - RECIP5_SHIFT;

    // config
    logic [MIN_GAP_W-1:0] r_min_gap;
    logic [STALE_W-1:0]   r_stale;
    logic [SPEED_W-1:0]   r_warn;
    logic [SPEED_W-1:0]   r_danger;
    logic [SPEED_W-1:0]   r_full_scale;

    // tachometer state
    logic [TIME_W-1:0]    r_last;
    logic [TIME_W-1:0]    r_period;
    logic [SPEED_W-1:0]   r_speed;
    logic [BW-1:0]        r_shown_width;
    t_zone                r_shown_zone;
    logic                 r_drawn;

    // working registers
    logic [TIME_W-1:0]    r_now;
    logic [PROD_W-1:0]    r_prod;
    logic [MUL_W-1:0]     r_mul;
    logic [BW-1:0]        r_width;

    logic [TIME_W-1:0]    gap_in;
    logic [TIME_W-1:0]    gap_ref;
    logic [SPEED_W-1:0]   scale;
    logic [DIV_NW-1:0]    div_num;
    logic [TIME_W-1:0]    div_den;
    logic [DIV_NW-1:0]    div_q;
    logic                 div_done;
    logic [SUM_W-1:0]     sum;
    logic [Q5_W-1:0]      q5;
    t_zone                zone;
    logic [BW-1:0]        fs, fl, cs, cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap    <= MIN_GAP_RST;
            r_stale      <= STALE_RST;
            r_warn       <= WARN_RST;
            r_danger     <= DANGER_RST;
            r_full_scale <= FULL_SCALE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_GAP:    r_min_gap    <= i_cfg_data[MIN_GAP_W-1:0];
                CFG_STALE:      r_stale      <= i_cfg_data[STALE_W-1:0];
                CFG_WARN:       r_warn       <= i_cfg_data[SPEED_W-1:0];
                CFG_DANGER:     r_danger     <= i_cfg_data[SPEED_W-1:0];
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign gap_in  = i_now_us - r_last;
    assign gap_ref = r_now - r_last;
    assign scale   = (r_full_scale == '0) ? SPEED_W'(1) : r_full_scale;

    always_comb begin
        o_sts.stale      = gap_ref > TIME_W'(r_stale);
        o_sts.has_period = r_period != '0;
        o_sts.div_done   = div_done;
    end

    assign div_num = (i_cmd.div_sel == DIV_INST) ? RPM_NUMERATOR : DIV_NW'(r_mul);
    assign div_den = (i_cmd.div_sel == DIV_INST) ? r_period : TIME_W'(scale);

    tbg_div #(
        .NW (DIV_NW),
        .DW (TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    assign sum = SUM_W'({r_speed, 2'b00}) + SUM_W'(div_q);
    assign q5  = r_prod[PROD_W-1:RECIP5_SHIFT];

    always_comb begin
        zone = ZONE_NORMAL;
        if (r_speed > r_warn)   zone = ZONE_WARN;
        if (r_speed > r_danger) zone = ZONE_DANGER;
    end

    always_comb begin
        fs = '0;
        fl = '0;
        cs = '0;
        cl = '0;
        priority if (!r_drawn || zone != r_shown_zone) begin
            fl = r_width;
            cs = r_width;
            cl = BAR_MAX - r_width;
        end else if (r_width > r_shown_width) begin
            fs = r_shown_width;
            fl = r_width - r_shown_width;
        end else if (r_width < r_shown_width) begin
            cs = r_width;
            cl = r_shown_width - r_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= '0;
            r_period      <= '0;
            r_speed       <= '0;
            r_shown_width <= '0;
            r_shown_zone  <= ZONE_NORMAL;
            r_drawn       <= 1'b0;
        end else begin
            if (i_cmd.pulse && gap_in > TIME_W'(r_min_gap)) begin
                r_period <= gap_in;
                r_last   <= i_now_us;
            end
            if (i_cmd.zero_speed) begin
                r_speed <= '0;
            end else if (i_cmd.smooth_sat) begin
                r_speed <= (|q5[Q5_W-1:SPEED_W]) ? '1 : q5[SPEED_W-1:0];
            end
            if (i_cmd.span_load) begin
                r_shown_width <= r_width;
                r_shown_zone  <= zone;
                r_drawn       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_now)    r_now  <= i_now_us;
        if (i_cmd.smooth_mul) r_prod <= sum * RECIP5;
        if (i_cmd.scale_mul)  r_mul  <= r_speed * BAR_MAX;
        if (i_cmd.width_load) begin
            r_width <= (div_q > DIV_NW'(BAR_LENGTH)) ? BAR_MAX : div_q[BW-1:0];
        end
        if (i_cmd.span_load) begin
            o_speed_rpm    <= r_speed;
            o_bar_width    <= PIX_W'(r_width);
            o_color_zone   <= zone;
            o_fill_start   <= PIX_W'(fs);
            o_fill_length  <= PIX_W'(fl);
            o_clear_start  <= PIX_W'(cs);
            o_clear_length <= PIX_W'(cl);
        end
    end

endmodule

`default_nettype wire

/* rtl/tbg_chk.sv */
// ----------------------------------------------------------------------------
// tbg_chk: port-level checks for the tachometer bar gauge
// Checks result hold behavior, span consistency and the zero-speed bar.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_chk import tbg_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [SPEED_W-1:0] o_speed_rpm,
    input wire logic [PIX_W-1:0]   o_bar_width,
    input wire logic [PIX_W-1:0]   o_fill_start,
    input wire logic [PIX_W-1:0]   o_fill_length,
    input wire logic [PIX_W-1:0]   o_clear_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_speed_rpm) && $stable(o_bar_width))
        else $error("result word changed while stalled");

    // growth has no clear span, shrink has no fill span
    a_one_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fill_length == '0 || o_clear_length == '0 ||
                         o_fill_start == '0))
        else $error("incremental update carries both spans");

    // a fill from the origin always covers the whole bar width
    a_fill_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fill_start == '0 && o_fill_length != '0 |->
        o_fill_length == o_bar_width)
        else $error("fill from origin does not match bar width");

    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_speed_rpm == '0 |-> o_bar_width == '0)
        else $error("zero speed with nonzero bar");

endmodule

bind tachometer_bar_gauge tbg_chk u_tbg_chk (.*);

`default_nettype wire

/* sim/tachometer_bar_gauge_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tachometer_bar_gauge_tb: self-checking bench for the tachometer bar gauge
// Drives pulse and refresh words through a directed table and then a long
// run of random shaft profiles under several register settings. A local
// model of the gauge predicts every result word. An output monitor compares
// each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tachometer_bar_gauge_tb;
    import tbg_pkg::*;

    localparam int BAR_PIX       = 458;
    localparam int USEC_PER_MIN  = 60_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 600;    // long result back-pressure burst
    localparam int N_PHASES      = 8;
    localparam int PHASE_WORDS   = 125;

    // one result word as the gauge reports it
    typedef struct packed {
        logic [SPEED_W-1:0] rpm;
        logic [PIX_W-1:0]   width;
        t_zone              zone;
        logic [PIX_W-1:0]   fill_start;
        logic [PIX_W-1:0]   fill_len;
        logic [PIX_W-1:0]   clear_start;
        logic [PIX_W-1:0]   clear_len;
    } gauge_update_t;

    // directed row: word to send, plus a hand-written result where obvious
    typedef struct packed {
        t_req          kind;
        logic [31:0]   now;
        logic          typed;
        gauge_update_t want;
    } plan_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_req_type = 1'b0;
    logic [TIME_W-1:0]     i_now_us = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SPEED_W-1:0]    o_speed_rpm;
    logic [PIX_W-1:0]      o_bar_width;
    logic [1:0]            o_color_zone;
    logic [PIX_W-1:0]      o_fill_start;
    logic [PIX_W-1:0]      o_fill_length;
    logic [PIX_W-1:0]      o_clear_start;
    logic [PIX_W-1:0]      o_clear_length;

    tachometer_bar_gauge #(
        .BAR_LENGTH     (BAR_PIX)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_now_us       (i_now_us),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_speed_rpm    (o_speed_rpm),
        .o_bar_width    (o_bar_width),
        .o_color_zone   (o_color_zone),
        .o_fill_start   (o_fill_start),
        .o_fill_length  (o_fill_length),
        .o_clear_start  (o_clear_start),
        .o_clear_length (o_clear_length)
    );

    // ------------------------------------------------------------------
    // Gauge model: registers and state, starting at their reset values
    // ------------------------------------------------------------------
    logic [MIN_GAP_W-1:0] cfg_min_gap = MIN_GAP_RST;
    logic [STALE_W-1:0]   cfg_stale   = STALE_RST;
    logic [SPEED_W-1:0]   cfg_warn    = WARN_RST;
    logic [SPEED_W-1:0]   cfg_danger  = DANGER_RST;
    logic [SPEED_W-1:0]   cfg_full    = FULL_SCALE_RST;

    logic [31:0]          last_edge_us   = '0;
    logic [31:0]          edge_period_us = '0;   // 0: no period measured yet
    logic [SPEED_W-1:0]   rpm_now        = '0;
    logic [PIX_W-1:0]     drawn_width    = '0;
    t_zone                drawn_zone     = ZONE_NORMAL;
    logic                 gauge_painted  = 1'b0;

    gauge_update_t        due_updates[$];        // predicted result words
    int                   mismatches = 0;
    bit                   hold_off_req = 1'b0;   // asks the receiver for a long stall

    // Advance the model by one accepted word; returns 1 if a result word is due.
    function automatic bit advance_gauge(input t_req kind, input logic [31:0] now,
                                         output gauge_update_t upd);
        logic [31:0]        gap;
        logic [31:0]        inst;
        logic [63:0]        blend;
        logic [63:0]        raw_width;
        logic [SPEED_W-1:0] scale;
        logic [PIX_W-1:0]   width;
        t_zone              zone;

        upd = '0;
        gap = now - last_edge_us;   // wraps with the microsecond counter

        if (kind == REQ_PULSE) begin
            // debounce: the gap must strictly exceed the minimum
            if (gap > 32'(cfg_min_gap)) begin
                edge_period_us = gap;
                last_edge_us   = now;
            end
            return 1'b0;
        end

        if (gap > 32'(cfg_stale)) begin
            rpm_now = '0;
        end else if (edge_period_us != 0) begin
            inst    = 32'(USEC_PER_MIN) / edge_period_us;
            blend   = (64'(rpm_now) * 64'd4 + 64'(inst)) / 64'd5;
            rpm_now = (blend > 64'hFFFF) ? 16'hFFFF : blend[SPEED_W-1:0];
        end

        scale     = (cfg_full == 0) ? 16'd1 : cfg_full;
        raw_width = 64'(rpm_now) * 64'(BAR_PIX) / 64'(scale);
        width     = (raw_width > 64'(BAR_PIX)) ? PIX_W'(BAR_PIX) : raw_width[PIX_W-1:0];

        // danger outranks warning even with crossed thresholds
        zone = ZONE_NORMAL;
        if (rpm_now > cfg_warn)   zone = ZONE_WARN;
        if (rpm_now > cfg_danger) zone = ZONE_DANGER;

        upd.rpm   = rpm_now;
        upd.width = width;
        upd.zone  = zone;
        if (!gauge_painted || zone != drawn_zone) begin
            // first paint or new color: repaint the whole bar
            upd.fill_len    = width;
            upd.clear_start = width;
            upd.clear_len   = PIX_W'(BAR_PIX) - width;
        end else if (width > drawn_width) begin
            upd.fill_start = drawn_width;
            upd.fill_len   = width - drawn_width;
        end else if (width < drawn_width) begin
            upd.clear_start = width;
            upd.clear_len   = drawn_width - width;
        end

        drawn_width   = width;
        drawn_zone    = zone;
        gauge_painted = 1'b1;
        return 1'b1;
    endfunction

    // Short gaps mostly, a few long ones.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Clock, time limit
    // ------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Word drivers. Everything is driven with NBAs right after the edge,
    // and ready/valid are sampled right after the edge (pre-edge values).
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        // only the register's own width is kept; unused indexes do nothing
        case (idx)
            CFG_MIN_GAP:    cfg_min_gap = data[MIN_GAP_W-1:0];
            CFG_STALE:      cfg_stale   = data[STALE_W-1:0];
            CFG_WARN:       cfg_warn    = data[SPEED_W-1:0];
            CFG_DANGER:     cfg_danger  = data[SPEED_W-1:0];
            CFG_FULL_SCALE: cfg_full    = data[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] min_gap,
                                 input logic [CFG_DATA_W-1:0] stale,
                                 input logic [CFG_DATA_W-1:0] warn,
                                 input logic [CFG_DATA_W-1:0] danger,
                                 input logic [CFG_DATA_W-1:0] full);
        write_reg(CFG_MIN_GAP, min_gap);
        write_reg(CFG_STALE, stale);
        write_reg(CFG_WARN, warn);
        write_reg(CFG_DANGER, danger);
        write_reg(CFG_FULL_SCALE, full);
        // indexes past the register list must be ignored
        for (int k = int'(CFG_FULL_SCALE) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one word after an optional idle gap; valid stays up until taken.
    task automatic offer_word(input t_req kind, input logic [31:0] now,
                              input logic typed, input gauge_update_t want,
                              input int idle);
        gauge_update_t predicted;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_now_us   <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // the model always runs so its state tracks the block
        if (advance_gauge(kind, now, predicted))
            due_updates.push_back(typed ? want : predicted);
    endtask

    // Let every predicted word come out, then give an in-flight word time.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_updates.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random shaft profiles: mostly pulse trains around one period with
    // refreshes in between, plus bounce, stale gaps and raw noise words.
    task automatic run_phase(input int ph, input int n_words);
        logic [31:0] period;
        logic [31:0] now;
        t_req        kind;
        int          roll;
        int          pick;
        int          idle;
        period = 32'd1;
        for (int i = 0; i < n_words; i++) begin
            if (i % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0:       period = 32'(cfg_min_gap) + 1 + $urandom_range(0, 2000);
                    1:       period = 32'(cfg_min_gap) + 1 + $urandom_range(0, 20000);
                    default: period = 32'(cfg_min_gap) + 1 + $urandom_range(0, 200000);
                endcase
            end
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            if (roll < 12) begin
                // noise: any kind, any time
                kind = t_req'($urandom_range(0, 1));
                now  = $urandom;
            end else if (roll < 55) begin
                kind = REQ_PULSE;
                if (pick < 7)
                    now = last_edge_us + period - period / 16 + $urandom_range(0, period / 8);
                else if (pick == 7)
                    now = last_edge_us + $urandom_range(0, cfg_min_gap);   // bounce
                else if (pick == 8)
                    now = last_edge_us + 32'(cfg_min_gap) + 1;             // just enough
                else
                    now = last_edge_us + 32'(cfg_min_gap);                 // just short
            end else begin
                kind = REQ_REFRESH;
                if (pick < 6)
                    now = last_edge_us + $urandom_range(0, period);
                else if (pick == 6)
                    now = last_edge_us;
                else if (pick == 7)
                    now = last_edge_us + 32'(cfg_stale);                   // still live
                else if (pick == 8)
                    now = last_edge_us + 32'(cfg_stale) + 1;               // just stale
                else
                    now = last_edge_us + $urandom_range(0, 2 * 32'(cfg_stale) + 2);
            end

            // odd phases open with a back-to-back stretch
            idle = (ph % 2 == 1 && i < 30) ? 0 : idle_cycles();

            if (ph == 0 && i == 40)
                hold_off_req = 1'b1;        // receiver stalls, sender keeps pushing
            if (ph == 3 && i == 60) begin
                // sender goes quiet until the block has emptied
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (due_updates.size() != 0);
            end

            offer_word(kind, now, 1'b0, '0, idle);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. Hand-written results only for the obvious rows:
    // first paint after reset, no-change refreshes, refresh with no period.
    // Default settings apply throughout.
    // ------------------------------------------------------------------
    plan_row_t directed_plan [0:24] = '{
        // first refresh: empty bar, full repaint with background
        '{REQ_REFRESH, 32'd0,      1'b1, '{16'd0, 9'd0, ZONE_NORMAL, 9'd0, 9'd0, 9'd0, 9'd458}},
        // same picture again: nothing to paint
        '{REQ_REFRESH, 32'd0,      1'b1, '{16'd0, 9'd0, ZONE_NORMAL, 9'd0, 9'd0, 9'd0, 9'd0}},
        '{REQ_PULSE,   32'd3000,   1'b0, '0},   // bounce, rejected
        '{REQ_PULSE,   32'd5000,   1'b0, '0},   // gap equals minimum, rejected
        // no period yet: speed holds at zero
        '{REQ_REFRESH, 32'd5000,   1'b1, '{16'd0, 9'd0, ZONE_NORMAL, 9'd0, 9'd0, 9'd0, 9'd0}},
        '{REQ_PULSE,   32'd5001,   1'b0, '0},   // first accepted edge
        '{REQ_REFRESH, 32'd5001,   1'b0, '0},   // bar grows
        '{REQ_PULSE,   32'd10002,  1'b0, '0},
        '{REQ_REFRESH, 32'd10500,  1'b0, '0},
        '{REQ_REFRESH, 32'd11000,  1'b0, '0},
        '{REQ_REFRESH, 32'd11500,  1'b0, '0},   // crosses into warning
        '{REQ_REFRESH, 32'd12000,  1'b0, '0},
        '{REQ_REFRESH, 32'd12500,  1'b0, '0},   // danger
        '{REQ_REFRESH, 32'd13000,  1'b0, '0},
        '{REQ_PULSE,   32'd60010,  1'b0, '0},   // long period, slowing down
        '{REQ_REFRESH, 32'd60010,  1'b0, '0},
        '{REQ_REFRESH, 32'd60020,  1'b0, '0},
        '{REQ_REFRESH, 32'd60030,  1'b0, '0},   // shrink in same zone
        '{REQ_REFRESH, 32'd560010, 1'b0, '0},   // exactly at the timeout, still live
        '{REQ_REFRESH, 32'd560011, 1'b0, '0},   // one past, speed drops to zero
        '{REQ_PULSE,   32'hFFFF_FF00, 1'b0, '0},
        '{REQ_PULSE,   32'h0000_2000, 1'b0, '0}, // gap wraps through zero
        '{REQ_REFRESH, 32'h0000_2000, 1'b0, '0},
        '{REQ_REFRESH, 32'hFFFF_FFFF, 1'b0, '0}, // huge wrapped gap, stale
        '{REQ_PULSE,   32'hFFFF_FFFF, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r])
            offer_word(directed_plan[r].kind, directed_plan[r].now,
                       directed_plan[r].typed, directed_plan[r].want, idle_cycles());

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: load_settings(24'd5000, 24'd500000, 24'd7000, 24'd8500, 24'd10000);
                // no debounce, longest timeout, every nonzero speed is danger, full scale 1
                1: load_settings(24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd1);
                // debounce masked to its top value, zero timeout, zero full scale
                2: load_settings(24'hFFFFFF, 24'd0, 24'd65535, 24'd65535, 24'd0);
                // danger threshold below warning
                3: load_settings(24'd1000000, 24'd2000000, 24'd3000, 24'd2000, 24'd65535);
                4: load_settings(24'd2000, 24'd300000, 24'd1000, 24'd4000, 24'd5000);
                7: load_settings(24'd5000, 24'd500000, 24'd7000, 24'd8500, 24'd10000);
                default: load_settings($urandom_range(0, 20000), $urandom_range(10000, 3000000),
                                       $urandom_range(0, 15000), $urandom_range(0, 15000),
                                       $urandom_range(1, 30000));
            endcase
            run_phase(ph, PHASE_WORDS);
        end

        drain_results();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure with occasional long ready runs,
    // plus one long hold-off when the stimulus asks for it.
    // ------------------------------------------------------------------
    initial begin
        int run;
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                i_out_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                stall = idle_cycles();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every accepted result word against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        gauge_update_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_updates.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual rpm %0d width %0d",
                         $time, o_speed_rpm, o_bar_width);
                mismatches++;
            end else begin
                want = due_updates.pop_front();
                check_field("speed_rpm",    want.rpm,         o_speed_rpm);
                check_field("bar_width",    want.width,       o_bar_width);
                check_field("color_zone",   want.zone,        o_color_zone);
                check_field("fill_start",   want.fill_start,  o_fill_start);
                check_field("fill_length",  want.fill_len,    o_fill_length);
                check_field("clear_start",  want.clear_start, o_clear_start);
                check_field("clear_length", want.clear_len,   o_clear_length);
            end
        end
    end

endmodule

/* tachometer_bar_gauge.f */
rtl/tbg_pkg.sv
rtl/tbg_div.sv
rtl/tbg_ctrl.sv
rtl/tbg_dp.sv
rtl/tachometer_bar_gauge.sv
rtl/tbg_chk.sv
sim/tachometer_bar_gauge_tb.sv
